FILE: hw/rtl/lsp_pkg.sv
`timescale 1ns / 1ps
package lsp_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int SD_W = 24;
   localparam int ERR_W = 26;
   localparam int CALC_W = 28;
   localparam int PIX_W = 14;
   localparam int INT_W = 8;
   localparam int QUO_W = 48;
   localparam int ROOT_W = 24;
   localparam int DIV_STEPS = QUO_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int CNT_W = $clog2(DIV_STEPS);
   localparam int INT_SHIFT = 16;

   // 16777087 squared
   localparam logic [QUO_W-1:0] SCALE_NUM_SQ = 48'd281470648205569;
   localparam logic signed [CALC_W-1:0] SIDE_LIMIT = 28'sd16711680;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       sqrt_step;
      logic       mul_x;
      logic       mul_y;
      logic       step;
      logic       emit;
      logic [1:0] emit_sel;
      logic       emit_last;
   } cmd_type;

   typedef struct packed {
      logic       line_active;
      logic [2:0] pix_valid;
   } status_type;

endpackage

FILE: hw/rtl/lsp_chan_if.sv
`timescale 1ns / 1ps
interface lsp_req_if #(parameter int CoordBits = 12);
   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [CoordBits-1:0] x_start;
   logic [CoordBits-1:0] y_start;
   logic [CoordBits-1:0] x_end;
   logic [CoordBits-1:0] y_end;

   modport source (output valid, op, x_start, y_start, x_end, y_end, input ready);
   modport sink (input valid, op, x_start, y_start, x_end, y_end, output ready);
endinterface

interface lsp_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [13:0] pixel_x;
   logic signed [13:0] pixel_y;
   logic [7:0]        intensity;
   logic              line_done;
   logic              last;

   modport source (output valid, pixel_x, pixel_y, intensity, line_done, last, input ready);
   modport sink (input valid, pixel_x, pixel_y, intensity, line_done, last, output ready);
endinterface

FILE: hw/rtl/lsp_ctrl.sv
`timescale 1ns / 1ps
module lsp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_op,
   output logic                req_ready,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   input  lsp_pkg::status_type status,
   output lsp_pkg::cmd_type    cmd
);
   import lsp_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_SQRT  = 3'd2;
   localparam logic [2:0] S_MULX  = 3'd3;
   localparam logic [2:0] S_MULY  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       sel_ff, sel_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept, slot_free, last_pix;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      case (sel_ff)
         2'd0:    last_pix = (status.pix_valid[2:1] == 2'b00);
         2'd1:    last_pix = !status.pix_valid[2];
         default: last_pix = 1'b1;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.emit_sel  = sel_ff;
      cmd.emit_last = last_pix;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_LOAD) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = S_DIV;
            end else if (accept && status.line_active) begin
               cmd.step = 1'b1;
               sel_in   = 2'd0;
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) state_in = S_MULX;
         end
         S_MULX: begin
            cmd.mul_x = 1'b1;
            state_in  = S_MULY;
         end
         S_MULY: begin
            cmd.mul_y = 1'b1;
            state_in  = S_IDLE;
         end
         S_EMIT: begin
            if (slot_free) begin
               if (status.pix_valid[sel_ff]) begin
                  cmd.emit = 1'b1;
                  if (last_pix) state_in = S_IDLE;
                  else sel_in = sel_ff + 2'd1;
               end else begin
                  sel_in = sel_ff + 2'd1;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         sel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready)) else $error("beat overwritten");
   a_load_div: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_DIV) else $error("load did not start divide");
   a_sel_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT |-> sel_ff != 2'd3) else $error("pixel select out of range");
   a_emit_first: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> status.pix_valid[0]) else $error("step without main pixel");
endmodule

FILE: hw/rtl/lsp_dpath.sv
`timescale 1ns / 1ps
module lsp_dpath #(
   parameter int CoordBits = lsp_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CoordBits-1:0]        x_start,
   input  logic [CoordBits-1:0]        y_start,
   input  logic [CoordBits-1:0]        x_end,
   input  logic [CoordBits-1:0]        y_end,
   input  lsp_pkg::cmd_type            cmd,
   output lsp_pkg::status_type         status,
   output logic signed [lsp_pkg::PIX_W-1:0] pixel_x,
   output logic signed [lsp_pkg::PIX_W-1:0] pixel_y,
   output logic [lsp_pkg::INT_W-1:0]   intensity,
   output logic                        line_done,
   output logic                        last
);
   import lsp_pkg::*;

   localparam int DW = 2 * CoordBits + 1;
   localparam int CW = CoordBits + 2;

   function automatic logic [INT_W-1:0] shade(input logic signed [CALC_W-1:0] v);
      logic [CALC_W-INT_SHIFT-1:0] hi;
      hi = v[CALC_W-1:INT_SHIFT];
      if (v < 0) return '0;
      else if (|hi[CALC_W-INT_SHIFT-1:INT_W]) return '1;
      else return hi[INT_W-1:0];
   endfunction

   // line state
   logic [CoordBits-1:0] cur_x_ff, cur_y_ff, tgt_x_ff, tgt_y_ff, adx_ff, ady_ff;
   logic                 xneg_ff, yneg_ff, dzero_ff, active_ff;
   logic [SD_W-1:0]      sdx_ff, sdy_ff;
   logic [ERR_W-1:0]     err_ff;
   // divide and root
   logic [DW-1:0]        den_ff, rem_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [ROOT_W-1:0]    root_ff;
   logic [ROOT_W:0]      srem_ff;
   // pixels of the current step
   logic signed [PIX_W-1:0] px_ff [3];
   logic signed [PIX_W-1:0] py_ff [3];
   logic [INT_W-1:0]     pi_ff [3];
   logic [2:0]           pv_ff;
   logic                 done_ff;
   // output register
   logic signed [PIX_W-1:0] ox_ff, oy_ff;
   logic [INT_W-1:0]     oi_ff;
   logic                 od_ff, ol_ff;

   logic [CoordBits-1:0] adx, ady;
   logic [DW-1:0]        dsq;
   logic [DW:0]          rem_sh;
   logic                 qbit;
   logic [ROOT_W+2:0]    srem_sh, trial;
   logic [ROOT_W-1:0]    scale;
   logic [ROOT_W+CoordBits-1:0] prod;

   logic signed [CALC_W-1:0] e, dx, dy, v, av, e2;
   logic                 xgo, ygo, xend, yend, xstop, xstep, ystep, done;
   logic signed [CW-1:0] xs, ys, sxv, syv;

   assign adx = (x_start < x_end) ? x_end - x_start : x_start - x_end;
   assign ady = (y_start < y_end) ? y_end - y_start : y_start - y_end;
   assign dsq = DW'(adx * adx) + DW'(ady * ady);

   assign rem_sh = {rem_ff, quo_ff[QUO_W-1]};
   assign qbit   = (rem_sh >= {1'b0, den_ff});

   assign srem_sh = {srem_ff, quo_ff[QUO_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};

   assign scale = dzero_ff ? ROOT_W'(1) : root_ff;
   assign prod  = scale * (cmd.mul_y ? ady_ff : adx_ff);

   assign e   = CALC_W'(signed'(err_ff));
   assign dx  = signed'(CALC_W'(sdx_ff));
   assign dy  = signed'(CALC_W'(sdy_ff));
   assign e2  = e <<< 1;
   assign v   = e - dx + dy;
   assign av  = (v < 0) ? -v : v;
   assign xgo = (e2 >= -dx);
   assign ygo = (e2 <= dy);
   assign xend = (cur_x_ff == tgt_x_ff);
   assign yend = (cur_y_ff == tgt_y_ff);
   assign xstop = xgo && xend;
   assign xstep = xgo && !xend;
   assign ystep = !xstop && ygo && !yend;
   assign done  = xstop || (ygo && yend);

   assign xs  = signed'(CW'(cur_x_ff));
   assign ys  = signed'(CW'(cur_y_ff));
   assign sxv = xneg_ff ? -CW'(1) : CW'(1);
   assign syv = yneg_ff ? -CW'(1) : CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pv_ff     <= '0;
      end else begin
         if (cmd.mul_y) active_ff <= 1'b1;
         else if (cmd.step && done) active_ff <= 1'b0;
         if (cmd.step) pv_ff <= {ystep && (dx - e < SIDE_LIMIT),
                                 xstep && (e + dy < SIDE_LIMIT), 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cur_x_ff <= x_start;
         cur_y_ff <= y_start;
         tgt_x_ff <= x_end;
         tgt_y_ff <= y_end;
         xneg_ff  <= !(x_start < x_end);
         yneg_ff  <= !(y_start < y_end);
         adx_ff   <= adx;
         ady_ff   <= ady;
         den_ff   <= dsq;
         dzero_ff <= (dsq == '0);
         quo_ff   <= SCALE_NUM_SQ;
         rem_ff   <= '0;
         root_ff  <= '0;
         srem_ff  <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= qbit ? DW'(rem_sh - {1'b0, den_ff}) : rem_sh[DW-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], qbit};
      end
      if (cmd.sqrt_step) begin
         quo_ff <= {quo_ff[QUO_W-3:0], 2'b00};
         if (srem_sh >= trial) begin
            srem_ff <= (ROOT_W+1)'(srem_sh - trial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= srem_sh[ROOT_W:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
      if (cmd.mul_x) sdx_ff <= prod[SD_W-1:0];
      if (cmd.mul_y) begin
         sdy_ff <= prod[SD_W-1:0];
         err_ff <= ERR_W'(sdx_ff) - ERR_W'(prod[SD_W-1:0]);
      end
      if (cmd.step) begin
         px_ff[0] <= PIX_W'(xs);
         py_ff[0] <= PIX_W'(ys);
         pi_ff[0] <= shade(av);
         px_ff[1] <= PIX_W'(xs);
         py_ff[1] <= PIX_W'(ys + syv);
         pi_ff[1] <= shade(e + dy);
         px_ff[2] <= PIX_W'(xs + sxv);
         py_ff[2] <= PIX_W'(ys);
         pi_ff[2] <= shade(dx - e);
         done_ff  <= done;
         if (xstep) cur_x_ff <= CoordBits'(xs + sxv);
         if (ystep) cur_y_ff <= CoordBits'(ys + syv);
         err_ff <= ERR_W'(e - (xstep ? dy : '0) + (ystep ? dx : '0));
      end
      if (cmd.emit) begin
         ox_ff <= px_ff[cmd.emit_sel];
         oy_ff <= py_ff[cmd.emit_sel];
         oi_ff <= pi_ff[cmd.emit_sel];
         od_ff <= done_ff;
         ol_ff <= cmd.emit_last;
      end
   end

   assign status.line_active = active_ff;
   assign status.pix_valid   = pv_ff;
   assign pixel_x   = ox_ff;
   assign pixel_y   = oy_ff;
   assign intensity = oi_ff;
   assign line_done = od_ff;
   assign last      = ol_ff;
endmodule

FILE: hw/rtl/antialiased_line_stepper.sv
`timescale 1ns / 1ps
// Anti-aliased line stepper. A load beat (op 0) takes two endpoints and
// works out the scale with a 48-step restoring divide, a 24-step bit-serial
// square root and two passes through one multiplier; no beat is taken
// meanwhile. A step beat (op 1) then gives one to three pixels, one at a
// time through the output register as the sink takes them; no new beat is
// taken until the last of them has entered the output register. A step with
// no line loaded gives nothing.
module antialiased_line_stepper #(
   parameter int COORD_BITS = lsp_pkg::COORD_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   lsp_req_if.sink    req_bus,
   lsp_rsp_if.source  rsp_bus
);
   import lsp_pkg::*;

   cmd_type    cmd;
   status_type status;

   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_op    (req_bus.op),
      .req_ready (req_bus.ready),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   lsp_dpath #(.CoordBits(COORD_BITS)) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .x_start   (req_bus.x_start),
      .y_start   (req_bus.y_start),
      .x_end     (req_bus.x_end),
      .y_end     (req_bus.y_end),
      .cmd       (cmd),
      .status    (status),
      .pixel_x   (rsp_bus.pixel_x),
      .pixel_y   (rsp_bus.pixel_y),
      .intensity (rsp_bus.intensity),
      .line_done (rsp_bus.line_done),
      .last      (rsp_bus.last)
   );
endmodule

FILE: tb/lsp_line_checker.sv
`timescale 1ns / 1ps
module lsp_line_checker (
   input  logic clock,
   input  logic reset,
   lsp_req_if   req_mon,
   lsp_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pixels_pending
);
   import lsp_pkg::*;

   localparam longint SCALE_NUM = 64'd16777087;
   localparam longint SIDE_LIM = 64'd16711680;
   localparam longint COORD_MASK = 64'hFFF;

   typedef struct packed {
      logic signed [PIX_W-1:0] px;
      logic signed [PIX_W-1:0] py;
      logic [INT_W-1:0]        inten;
      logic                    done;
      logic                    last;
   } pixel_type;

   pixel_type pixel_q[$];

   // line state
   longint pos_x, pos_y, end_x, end_y, sdx, sdy, err_acc;
   logic   neg_x, neg_y, active;

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [INT_W-1:0] coverage(longint v);
      longint u;
      if (v < 0) return '0;
      u = v >>> INT_SHIFT;
      return (u > 255) ? 8'd255 : u[7:0];
   endfunction

   task automatic latch_line(longint x0, longint y0, longint x1, longint y1);
      longint adx, ady, d, sc;
      adx = (x0 < x1) ? x1 - x0 : x0 - x1;
      ady = (y0 < y1) ? y1 - y0 : y0 - y1;
      d = adx * adx + ady * ady;
      sc = (d != 0) ? int_sqrt((SCALE_NUM * SCALE_NUM) / d) : 1;
      pos_x = x0; pos_y = y0; end_x = x1; end_y = y1;
      neg_x = !(x0 < x1);
      neg_y = !(y0 < y1);
      sdx = adx * sc;
      sdy = ady * sc;
      err_acc = sdx - sdy;
      active = 1'b1;
   endtask

   task automatic advance_line();
      pixel_type run[3];
      int     n;
      logic   fin;
      longint x, y, x_old, sx, sy, e, v;
      n = 0;
      fin = 1'b0;
      x = pos_x; y = pos_y; x_old = x;
      sx = neg_x ? -1 : 1;
      sy = neg_y ? -1 : 1;
      e = err_acc;
      v = e - sdx + sdy;
      run[n] = '{x[PIX_W-1:0], y[PIX_W-1:0], coverage(v < 0 ? -v : v), 1'b0, 1'b0};
      n++;
      if (2 * e >= -sdx) begin
         if (x == end_x) fin = 1'b1;
         else begin
            if (e + sdy < SIDE_LIM) begin
               v = y + sy;
               run[n] = '{x[PIX_W-1:0], v[PIX_W-1:0], coverage(e + sdy), 1'b0, 1'b0};
               n++;
            end
            err_acc -= sdy;
            x = (x + sx) & COORD_MASK;
         end
      end
      if (!fin && 2 * e <= sdy) begin
         if (y == end_y) fin = 1'b1;
         else begin
            if (sdx - e < SIDE_LIM) begin
               v = x_old + sx;
               run[n] = '{v[PIX_W-1:0], y[PIX_W-1:0], coverage(sdx - e), 1'b0, 1'b0};
               n++;
            end
            err_acc += sdx;
            y = (y + sy) & COORD_MASK;
         end
      end
      pos_x = x;
      pos_y = y;
      if (fin) active = 1'b0;
      for (int k = 0; k < n; k++) begin
         run[k].done = fin;
         run[k].last = (k == n - 1);
         pixel_q.push_back(run[k]);
      end
   endtask

   task automatic report(string what, longint got, longint want);
      $display("%0t: pixel mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign pixels_pending = pixel_q.size();

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         pixel_q.delete();
         pos_x = 0; pos_y = 0; end_x = 0; end_y = 0;
         sdx = 0; sdy = 0; err_acc = 0;
         neg_x = 0; neg_y = 0; active = 0;
         fail_count = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_LOAD)
               latch_line(req_mon.x_start, req_mon.y_start, req_mon.x_end, req_mon.y_end);
            else if (active)
               advance_line();
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pixel_q.size() == 0) begin
               report("unexpected beat", 1, 0);
            end else begin
               want = pixel_q.pop_front();
               if (rsp_mon.pixel_x !== want.px) report("pixel_x", rsp_mon.pixel_x, want.px);
               if (rsp_mon.pixel_y !== want.py) report("pixel_y", rsp_mon.pixel_y, want.py);
               if (rsp_mon.intensity !== want.inten)
                  report("intensity", rsp_mon.intensity, want.inten);
               if (rsp_mon.line_done !== want.done)
                  report("line_done", rsp_mon.line_done, want.done);
               if (rsp_mon.last !== want.last) report("last", rsp_mon.last, want.last);
            end
         end
      end
   end
endmodule

FILE: tb/tb_antialiased_line_stepper.sv
`timescale 1ns / 1ps
module tb_antialiased_line_stepper;
   import lsp_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic quiet = 1'b0;
   logic hold_go = 1'b0;
   logic hold_taken = 1'b0;
   int   hold_cnt = 0;
   int   fail_count, pixels_pending;
   int   beats_sent = 0;

   lsp_req_if #(.CoordBits(12)) req_if ();
   lsp_rsp_if rsp_if ();

   antialiased_line_stepper uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   lsp_line_checker chk (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .fail_count     (fail_count),
      .pixels_pending (pixels_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sink side: random stalls per beat, plus one long hold-off
   always @(posedge clock) begin
      int n;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_cnt <= 0;
      end else if (hold_go && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_cnt <= 300;
         rsp_if.ready <= 1'b0;
      end else if (hold_cnt > 1) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_cnt == 1) begin
         hold_cnt <= 0;
         rsp_if.ready <= 1'b1;
      end else if (rsp_if.ready && rsp_if.valid) begin
         n = quiet ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_if.ready <= 1'b0;
            hold_cnt <= n;
         end
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   task automatic send(logic op, int xs, int ys, int xe, int ye);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.x_start <= xs[11:0];
      req_if.y_start <= ys[11:0];
      req_if.x_end <= xe[11:0];
      req_if.y_end <= ye[11:0];
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic draw_line(int xs, int ys, int xe, int ye, int steps);
      send(OP_LOAD, xs, ys, xe, ye);
      repeat (steps) send(OP_STEP, $urandom, $urandom, $urandom, $urandom);
   endtask

   function automatic int near(int base);
      int p;
      p = base + $signed($urandom_range(0, 30)) - 15;
      return (p < 0) ? 0 : (p > 4095 ? 4095 : p);
   endfunction

   initial begin
      int xs, ys, xe, ye, len;
      req_if.valid = 1'b0;
      req_if.op = OP_STEP;
      req_if.x_start = '0;
      req_if.y_start = '0;
      req_if.x_end = '0;
      req_if.y_end = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send(OP_STEP, 4095, 4095, 4095, 4095);       // nothing loaded
      draw_line(4095, 4095, 4095, 4095, 2);        // zero length, then idle step
      draw_line(0, 0, 4095, 4095, 3);              // diagonal, replaced below
      draw_line(4095, 0, 0, 4095, 2);
      draw_line(10, 5, 16, 5, 8);                  // horizontal
      draw_line(7, 4095, 7, 4090, 7);              // vertical, negative y
      draw_line(100, 100, 103, 110, 12);           // steep
      send(OP_STEP, 0, 0, 0, 0);

      // random
      while (beats_sent < 260) begin
         quiet <= ($urandom_range(0, 5) == 0);
         if (beats_sent > 120 && !hold_go) hold_go <= 1'b1;
         if ($urandom_range(0, 9) < 8) begin
            xs = $urandom_range(0, 4095);
            ys = $urandom_range(0, 4095);
            xe = near(xs);
            ye = near(ys);
            len = (xe > xs ? xe - xs : xs - xe) + (ye > ys ? ye - ys : ys - ye);
            draw_line(xs, ys, xe, ye, len + $urandom_range(0, 1));
         end else if ($urandom_range(0, 1)) begin
            // long line cut short by the next load
            draw_line($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 4));
         end else begin
            send(OP_STEP, $urandom, $urandom, $urandom, $urandom);
         end
      end
      req_if.valid <= 1'b0;

      while (pixels_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("antialiased_line_stepper test passed");
      else
         $display("antialiased_line_stepper test failed");
      $finish;
   end

   initial begin
      #5ms;
      $display("antialiased_line_stepper test failed");
      $finish;
   end
endmodule
